[rtl/isd_pkg.sv]
// Package for the indentation style detector: item structs, codes, constants
// and small helper functions. Depends on nothing; the divider and the top level import it.
`default_nettype none
package isd_pkg;

  localparam int unsigned LINE_BUFFER_BYTES_DEF = 256;
  localparam int unsigned MAX_STEP               = 8;
  localparam int unsigned HIST_DEPTH             = MAX_STEP + 1;
  localparam int unsigned CFG_ADDR_W             = 3;
  localparam logic [15:0] MAX_LINES_RESET        = 16'd10000;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  // Register index of max_lines_inspected.
  localparam logic REG_MAX_LINES = 1'b0;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_EOL    = 2'd1,
    OP_FINISH = 2'd2
  } op_e;

  localparam logic [1:0] MODE_UNDECIDED = 2'd0;
  localparam logic [1:0] MODE_SOFT      = 2'd1;
  localparam logic [1:0] MODE_HARD      = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BYTE,
    S_EOL,
    S_DIFF,
    S_AL1,
    S_AL2,
    S_AL3,
    S_DIV,
    S_COMMIT,
    S_SCAN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  tab_mode;
    logic [3:0]  indent_step;
    logic [15:0] lines_inspected;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quot;
    logic        rem_zero;
  } div_rsp_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] sub_floor(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a - b : 16'd0;
  endfunction

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Preference order of the step search: 2, 4, 6, 8, 3, 5, 7.
  function automatic logic [3:0] step_order(input logic [2:0] k);
    logic [3:0] s;
    case (k)
      3'd0:    s = 4'd2;
      3'd1:    s = 4'd4;
      3'd2:    s = 4'd6;
      3'd3:    s = 4'd8;
      3'd4:    s = 4'd3;
      3'd5:    s = 4'd5;
      default: s = 4'd7;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

[rtl/isd_divider.sv]
// Iterative restoring divider, one quotient bit a cycle, 16 quotient bits a division.
// Depends on isd_pkg for the request and response structs.
`default_nettype none
module isd_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  isd_pkg::div_req_t  req_i,
  output isd_pkg::div_rsp_t  rsp_o
);
  import isd_pkg::*;

  logic [15:0] quo_q, rem_q, dsr_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [16:0] shifted, trial;

  assign shifted = {rem_q, quo_q[15]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!trial[16]) begin
        rem_q <= trial[15:0];
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= shifted[15:0];
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quot     = quo_q;
  assign rsp_o.rem_zero = (rem_q == 16'd0);

endmodule
`default_nettype wire

[rtl/isd_line_mem.sv]
// Line buffer memory holding two banks, previous and current line, which swap
// roles at each kept line other than an aligned continuation. One write and one registered read a cycle.
`default_nettype none
module isd_line_mem #(
  parameter int unsigned ADDR_W = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);
  logic [7:0] mem [2**ADDR_W];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/indent_style_detector_unit.sv]
// Top level of the indentation style detector: sequencer, counters, histogram
// and APB register. Depends on isd_pkg, isd_line_mem and isd_divider.
//
//  channel   direction  handshake            payload
//  in        input      in_valid_i/in_ready_o  isd_pkg::in_item_t
//  out       output     out_valid_o/out_ready_i isd_pkg::out_item_t
//  apb       input      psel/penable/pready      paddr, pwdata, prdata
//
// A text byte goes through one line buffer read, then the update.
// An end of line is dropped, or for a kept line takes the step difference, then
// where needed the alignment check, which reads the buffer twice, or the
// divider when the step needs a division, and then the commit.
// A finish runs the end of line work, a histogram scan over the seven steps and
// the output state; it waits there while an earlier result is still not taken.
// Reset is asynchronous and needs no clearing pass; a waiting result blocks text
// bytes and end-of-line items only while a later finish waits in the output state.
`default_nettype none
module indent_style_detector_unit #(
  parameter int unsigned LINE_BUFFER_BYTES = isd_pkg::LINE_BUFFER_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  isd_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output isd_pkg::out_item_t               out_item_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [isd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import isd_pkg::*;

  localparam int unsigned AW = $clog2(LINE_BUFFER_BYTES);
  localparam logic [15:0] BUF_N = 16'(LINE_BUFFER_BYTES);

  state_e      state_q, state_d;
  logic [7:0]  byte_q;
  logic        fin_q;
  logic        prev_bank_q;
  logic [15:0] prev_size_q, prev_sp_q, prev_tb_q;
  logic        prev_comma_q;
  logic [15:0] cur_size_q, cur_sp_q, cur_tb_q;
  logic        in_lead_q, has_content_q;
  logic [7:0]  last_q;
  logic        pfx_open_q;
  logic [15:0] pfx_sp_q, pfx_tb_q;
  logic [15:0] insp_q, tabl_q, spl_q;
  logic [15:0] hist_q [HIST_DEPTH];
  logic [15:0] a_sp_q, a_tb_q, b_sp_q, b_tb_q;
  logic [15:0] step_q;
  logic        align_q;
  logic [7:0]  cur_byte_q;
  logic [2:0]  scan_k_q;
  logic [3:0]  best_q;
  logic [15:0] hits_q;
  logic [15:0] max_lines_q;
  out_item_t   out_q;
  logic        out_valid_q;

  logic          in_acc, kept, mixed, al_cond, is_ws, pfx_match, out_free;
  logic [15:0]   sd, td, bm1, scan_val;
  logic [16:0]   prev_sum;
  logic [AW:0]   raddr, waddr;
  logic          we;
  logic [7:0]    rdata;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  isd_line_mem #(.ADDR_W(AW + 1)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (byte_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  isd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_MAX_LINES) ? {16'd0, max_lines_q} : 32'd0;

  assign kept     = has_content_q && (insp_q < max_lines_q);
  assign sd       = abs_diff(a_sp_q, b_sp_q);
  assign td       = abs_diff(a_tb_q, b_tb_q);
  assign mixed    = ((a_sp_q != 0) && (a_tb_q != 0)) || ((b_sp_q != 0) && (b_tb_q != 0));
  assign bm1      = b_sp_q - 16'd1;
  assign al_cond  = (sd != 0) && (b_sp_q != 0) && (bm1 < prev_size_q) &&
                    (b_sp_q < cur_size_q) && (b_sp_q < BUF_N) && prev_comma_q;
  assign prev_sum = {1'b0, prev_sp_q} + {1'b0, prev_tb_q};
  assign is_ws    = (byte_q == CHAR_SPACE) || (byte_q == CHAR_TAB);
  assign pfx_match = pfx_open_q && ({1'b0, cur_size_q} < prev_sum) &&
                     (cur_size_q < BUF_N) && (rdata == byte_q);
  assign scan_val = hist_q[step_order(scan_k_q)];

  // Bank prev_bank_q holds the last kept line that was not an aligned continuation, the other the current one.
  always_comb begin
    unique case (state_q)
      S_AL1:   raddr = {~prev_bank_q, b_sp_q[AW-1:0]};
      S_AL2:   raddr = {prev_bank_q, bm1[AW-1:0]};
      default: raddr = {prev_bank_q, cur_size_q[AW-1:0]};
    endcase
  end
  assign we    = (state_q == S_BYTE) && (cur_size_q < BUF_N);
  assign waddr = {~prev_bank_q, cur_size_q[AW-1:0]};

  assign div_req.start    = (state_q == S_DIFF) && !mixed && (td != 0);
  assign div_req.dividend = sd;
  assign div_req.divisor  = td;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_item_i.operation) inside
            OP_BYTE:             state_d = S_BYTE;
            OP_EOL, OP_FINISH:   state_d = S_EOL;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_BYTE:   state_d = S_IDLE;
      S_EOL:    state_d = kept ? S_DIFF : (fin_q ? S_SCAN : S_IDLE);
      S_DIFF: begin
        if (mixed)          state_d = S_COMMIT;
        else if (td != 0)   state_d = S_DIV;
        else if (al_cond)   state_d = S_AL1;
        else                state_d = S_COMMIT;
      end
      S_AL1:    state_d = S_AL2;
      S_AL2:    state_d = S_AL3;
      S_AL3:    state_d = S_COMMIT;
      S_DIV:    state_d = div_rsp.done ? S_COMMIT : S_DIV;
      S_COMMIT: state_d = fin_q ? S_SCAN : S_IDLE;
      S_SCAN:   state_d = (scan_k_q == 3'd6) ? S_OUT : S_SCAN;
      S_OUT:    state_d = out_free ? S_IDLE : S_OUT;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Items in the working registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= in_item_i.text_byte;
    end
    if (state_q == S_EOL) begin
      a_sp_q <= sub_floor(prev_sp_q, pfx_sp_q);
      a_tb_q <= sub_floor(prev_tb_q, pfx_tb_q);
      b_sp_q <= sub_floor(cur_sp_q, pfx_sp_q);
      b_tb_q <= sub_floor(cur_tb_q, pfx_tb_q);
    end
    if (state_q == S_AL2) begin
      cur_byte_q <= rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q        <= 1'b0;
      prev_bank_q  <= 1'b0;
      prev_size_q  <= '0;
      prev_sp_q    <= '0;
      prev_tb_q    <= '0;
      prev_comma_q <= 1'b0;
      cur_size_q   <= '0;
      cur_sp_q     <= '0;
      cur_tb_q     <= '0;
      in_lead_q    <= 1'b1;
      has_content_q <= 1'b0;
      last_q       <= '0;
      pfx_open_q   <= 1'b1;
      pfx_sp_q     <= '0;
      pfx_tb_q     <= '0;
      insp_q       <= '0;
      tabl_q       <= '0;
      spl_q        <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) hist_q[i] <= '0;
      step_q       <= '0;
      align_q      <= 1'b0;
      scan_k_q     <= '0;
      best_q       <= '0;
      hits_q       <= '0;
      max_lines_q  <= MAX_LINES_RESET;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (psel && penable && pwrite && (paddr[2] == REG_MAX_LINES)) begin
        max_lines_q <= pwdata[15:0];
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            fin_q <= (in_item_i.operation == OP_FINISH);
          end
          scan_k_q <= '0;
          best_q   <= '0;
          hits_q   <= '0;
        end
        S_BYTE: begin
          cur_size_q <= sat_inc(cur_size_q);
          last_q     <= byte_q;
          if (in_lead_q) begin
            if (is_ws) begin
              if (pfx_match) begin
                if (byte_q == CHAR_SPACE) pfx_sp_q <= pfx_sp_q + 16'd1;
                else                      pfx_tb_q <= pfx_tb_q + 16'd1;
              end else begin
                pfx_open_q <= 1'b0;
              end
              if (byte_q == CHAR_SPACE) cur_sp_q <= sat_inc(cur_sp_q);
              else                      cur_tb_q <= sat_inc(cur_tb_q);
            end else begin
              in_lead_q     <= 1'b0;
              has_content_q <= 1'b1;
              pfx_open_q    <= 1'b0;
            end
          end
        end
        S_EOL: begin
          if (kept) begin
            insp_q <= sat_inc(insp_q);
            if (cur_tb_q != 0)      tabl_q <= sat_inc(tabl_q);
            else if (cur_sp_q > 1)  spl_q  <= sat_inc(spl_q);
          end else begin
            cur_size_q    <= '0;
            cur_sp_q      <= '0;
            cur_tb_q      <= '0;
            in_lead_q     <= 1'b1;
            has_content_q <= 1'b0;
            last_q        <= '0;
            pfx_open_q    <= 1'b1;
            pfx_sp_q      <= '0;
            pfx_tb_q      <= '0;
          end
        end
        S_DIFF: begin
          align_q <= 1'b0;
          step_q  <= (mixed || (td != 0)) ? 16'd0 : sd;
        end
        S_AL3: begin
          align_q <= (cur_byte_q != CHAR_SPACE) && (rdata == CHAR_SPACE);
        end
        S_DIV: begin
          if (div_rsp.done) begin
            step_q <= div_rsp.rem_zero ? div_rsp.quot : 16'd0;
          end
        end
        S_COMMIT: begin
          if (!align_q) begin
            if (step_q <= 16'(MAX_STEP)) begin
              hist_q[step_q[3:0]] <= sat_inc(hist_q[step_q[3:0]]);
            end
            prev_bank_q  <= ~prev_bank_q;
            prev_size_q  <= cur_size_q;
            prev_sp_q    <= cur_sp_q;
            prev_tb_q    <= cur_tb_q;
            prev_comma_q <= (last_q == CHAR_COMMA);
          end
          cur_size_q    <= '0;
          cur_sp_q      <= '0;
          cur_tb_q      <= '0;
          in_lead_q     <= 1'b1;
          has_content_q <= 1'b0;
          last_q        <= '0;
          pfx_open_q    <= 1'b1;
          pfx_sp_q      <= '0;
          pfx_tb_q      <= '0;
        end
        S_SCAN: begin
          if (scan_val > hits_q) begin
            hits_q <= scan_val;
            best_q <= step_order(scan_k_q);
          end
          scan_k_q <= scan_k_q + 3'd1;
        end
        S_OUT: begin
          if (out_free) begin
            if (tabl_q != spl_q) out_q.tab_mode <= (tabl_q < spl_q) ? MODE_SOFT : MODE_HARD;
            else                 out_q.tab_mode <= MODE_UNDECIDED;
            if (tabl_q <= spl_q) begin
              // Step 4 yields to step 2 when 2 is at least half as common.
              if ((best_q == 4'd4) && (hist_q[2] != 0) &&
                  ({hist_q[2], 1'b0} >= {1'b0, hist_q[4]})) begin
                out_q.indent_step <= 4'd2;
              end else begin
                out_q.indent_step <= best_q;
              end
            end else begin
              out_q.indent_step <= 4'd0;
            end
            out_q.lines_inspected <= insp_q;
            prev_size_q  <= '0;
            prev_sp_q    <= '0;
            prev_tb_q    <= '0;
            prev_comma_q <= 1'b0;
            insp_q       <= '0;
            tabl_q       <= '0;
            spl_q        <= '0;
            for (int i = 0; i < HIST_DEPTH; i++) hist_q[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The common prefix never outgrows the leading run it is part of.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pfx_sp_q <= cur_sp_q) && (pfx_tb_q <= cur_tb_q))
    else $error("prefix count exceeds leading count");

  // Content ends the leading run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_content_q |-> !in_lead_q)
    else $error("content seen while still in leading whitespace");

  // The divider works only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == S_DIV))
    else $error("divider busy outside division wait");

  // A new result only appears after the report cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside report");

endmodule
`default_nettype wire

[sim/indent_style_detector_unit_test.sv]
// Self-checking test of indent_style_detector_unit: text files go in as byte,
// end-of-line and finish items and every report is checked against a predictor.
// Depends on isd_pkg and the detector RTL.
`timescale 1ns / 100ps
`default_nettype none
module indent_style_detector_unit_test;
  import isd_pkg::*;

  localparam int unsigned BUF_BYTES = LINE_BUFFER_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  indent_style_detector_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state.
  logic [15:0] max_lines;
  logic [7:0]  prev_buf [BUF_BYTES];
  logic [7:0]  cur_buf [BUF_BYTES];
  logic [15:0] prev_size, prev_sp, prev_tb;
  logic        prev_comma;
  logic [15:0] cur_size, cur_sp, cur_tb;
  logic        leading, content;
  logic [7:0]  last_byte;
  logic        pfx_open;
  logic [15:0] pfx_sp, pfx_tb;
  logic [15:0] seen_lines, hard_count, soft_count;
  logic [15:0] step_tally [MAX_STEP+1];

  in_item_t  text_items[$];
  out_item_t reports_due[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic        in_taken = 1'b0;

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] floor_sub(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a - b : 16'd0;
  endfunction

  task automatic reset_line();
    cur_size = 0; cur_sp = 0; cur_tb = 0; leading = 1; content = 0;
    last_byte = 0; pfx_open = 1; pfx_sp = 0; pfx_tb = 0;
  endtask

  task automatic reset_file();
    prev_size = 0; prev_sp = 0; prev_tb = 0; prev_comma = 0;
    reset_line();
    seen_lines = 0; hard_count = 0; soft_count = 0;
    for (int k = 0; k <= MAX_STEP; k++) step_tally[k] = 0;
  endtask

  task automatic add_byte(input logic [7:0] b);
    int unsigned pos;
    pos = cur_size;
    if (pos < BUF_BYTES) cur_buf[pos] = b;
    cur_size = bump(cur_size);
    last_byte = b;
    if (leading) begin
      if (b == CHAR_SPACE || b == CHAR_TAB) begin
        if (pfx_open && pos < int'(prev_sp) + int'(prev_tb) && pos < BUF_BYTES &&
            prev_buf[pos] == b) begin
          if (b == CHAR_SPACE) pfx_sp++;
          else pfx_tb++;
        end else begin
          pfx_open = 0;
        end
        if (b == CHAR_SPACE) cur_sp = bump(cur_sp);
        else cur_tb = bump(cur_tb);
      end else begin
        leading = 0; content = 1; pfx_open = 0;
      end
    end
  endtask

  task automatic close_line();
    logic [15:0] a_sp, a_tb, b_sp, b_tb, sd, td;
    int unsigned step;
    logic aligned;
    step = 0;
    aligned = 0;
    if (content && seen_lines < max_lines) begin
      seen_lines = bump(seen_lines);
      if (cur_tb > 0) hard_count = bump(hard_count);
      else if (cur_sp > 1) soft_count = bump(soft_count);
      a_sp = floor_sub(prev_sp, pfx_sp);
      a_tb = floor_sub(prev_tb, pfx_tb);
      b_sp = floor_sub(cur_sp, pfx_sp);
      b_tb = floor_sub(cur_tb, pfx_tb);
      if (!((a_sp > 0 && a_tb > 0) || (b_sp > 0 && b_tb > 0))) begin
        td = (a_tb > b_tb) ? a_tb - b_tb : b_tb - a_tb;
        sd = (a_sp > b_sp) ? a_sp - b_sp : b_sp - a_sp;
        if (td == 0) begin
          step = sd;
          // Continuation lined up after a space of a line ending in a comma.
          if (sd > 0 && b_sp >= 1 && b_sp - 1 < prev_size && b_sp < cur_size &&
              b_sp < BUF_BYTES && prev_comma && cur_buf[b_sp] != CHAR_SPACE &&
              prev_buf[b_sp - 1] == CHAR_SPACE)
            aligned = 1;
        end else if (sd % td == 0) begin
          step = sd / td;
        end
      end
      if (!aligned) begin
        if (step <= MAX_STEP) step_tally[step] = bump(step_tally[step]);
        prev_buf = cur_buf;
        prev_size = cur_size; prev_sp = cur_sp; prev_tb = cur_tb;
        prev_comma = (last_byte == CHAR_COMMA);
      end
    end
    reset_line();
  endtask

  task automatic predict_report();
    out_item_t r;
    logic [3:0] best;
    logic [15:0] top_tally;
    logic [3:0] order [7];
    order = '{4'd2, 4'd4, 4'd6, 4'd8, 4'd3, 4'd5, 4'd7};
    if (content) close_line();
    r = '0;
    if (hard_count != soft_count) r.tab_mode = (hard_count < soft_count) ? MODE_SOFT : MODE_HARD;
    if (hard_count <= soft_count) begin
      best = 0; top_tally = 0;
      for (int k = 0; k < 7; k++)
        if (step_tally[order[k]] > top_tally) begin
          top_tally = step_tally[order[k]];
          best = order[k];
        end
      if (best == 4 && step_tally[2] > 0 && {step_tally[2], 1'b0} >= {1'b0, step_tally[4]})
        best = 2;
      r.indent_step = best;
    end
    r.lines_inspected = seen_lines;
    reports_due.push_back(r);
    reset_file();
  endtask

  task automatic queue_item(input logic [1:0] op, input logic [7:0] b);
    in_item_t it;
    it.operation = op;
    it.text_byte = b;
    text_items.push_back(it);
    case (op)
      OP_BYTE:   add_byte(b);
      OP_EOL:    close_line();
      OP_FINISH: predict_report();
      default: ;
    endcase
  endtask

  task automatic queue_line(input int unsigned sp, input int unsigned tb, input bit tabs_first,
                            input int unsigned body, input bit comma);
    for (int k = 0; k < int'(sp + tb); k++)
      queue_item(OP_BYTE, ((tabs_first && k < tb) || (!tabs_first && k >= sp)) ?
                 CHAR_TAB : CHAR_SPACE);
    for (int k = 0; k < int'(body); k++) begin
      logic [7:0] c;
      c = ($urandom_range(0, 5) == 0) ? CHAR_SPACE : 8'($urandom_range(33, 255));
      queue_item(OP_BYTE, c);
    end
    if (comma) queue_item(OP_BYTE, CHAR_COMMA);
    queue_item(OP_EOL, 8'h00);
  endtask

  task automatic wait_drained();
    while (text_items.size() != 0 || reports_due.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_max_lines(input logic [15:0] v);
    @(negedge clk_i);
    psel = 1; penable = 0; pwrite = 1; paddr = {REG_MAX_LINES, 2'b00}; pwdata = {16'h0, v};
    @(negedge clk_i);
    penable = 1;
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
    max_lines = v;
  endtask

  // Records whether the item on the input was taken at the last rising edge.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
  end

  // Sender: pops pending items at the falling edge, with random gaps.
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    if (in_valid_i && !in_taken) begin
      // Hold the item until it is taken.
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      in_valid_i <= 1'b0;
    end else if (text_items.size() != 0) begin
      in_item_i <= text_items.pop_front();
      in_valid_i <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver stalls.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 9) == 0) out_ready_i <= ($urandom_range(0, 3) != 0);
    else if ($urandom_range(0, 29) == 0) out_ready_i <= 1'b0;
    else out_ready_i <= 1'b1;
  end

  // Monitor.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (out_valid_o && out_ready_i) begin
      if (reports_due.size() == 0) begin
        $error("report with none expected");
        errors = errors + 1;
      end else begin
        out_item_t e;
        e = reports_due.pop_front();
        if (out_item_o.tab_mode !== e.tab_mode) begin
          $error("tab_mode expected %0d actual %0d", e.tab_mode, out_item_o.tab_mode);
          errors = errors + 1;
        end
        if (out_item_o.indent_step !== e.indent_step) begin
          $error("indent_step expected %0d actual %0d", e.indent_step,
                 out_item_o.indent_step);
          errors = errors + 1;
        end
        if (out_item_o.lines_inspected !== e.lines_inspected) begin
          $error("lines_inspected expected %0d actual %0d", e.lines_inspected,
                 out_item_o.lines_inspected);
          errors = errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned n_items;
    int unsigned base;
    bit drained_once;
    drained_once = 1'b0;
    max_lines = MAX_LINES_RESET;
    for (int k = 0; k < BUF_BYTES; k++) begin
      prev_buf[k] = 0;
      cur_buf[k] = 0;
    end
    reset_file();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: steps 2 and 4, a tab file, alignment, mixed runs, extremes.
    queue_line(0, 0, 0, 3, 0);
    queue_line(2, 0, 0, 3, 0);
    queue_line(4, 0, 0, 3, 1);
    queue_line(5, 0, 0, 2, 0);
    queue_line(2, 1, 0, 2, 0);
    queue_line(3, 0, 0, 0, 0);
    queue_item(OP_BYTE, 8'h00);
    queue_item(OP_BYTE, 8'hFF);
    queue_item(2'd3, 8'hA5);
    queue_item(OP_FINISH, 8'h5A);
    queue_line(0, 1, 1, 2, 0);
    queue_line(0, 2, 1, 2, 0);
    queue_line(4, 2, 1, 1, 0);
    queue_item(OP_FINISH, 8'h00);
    queue_item(OP_FINISH, 8'h00);
    wait_drained();

    write_max_lines(16'd1);
    queue_line(0, 0, 0, 2, 0);
    queue_line(4, 0, 0, 2, 0);
    queue_item(OP_FINISH, 8'h00);
    wait_drained();
    write_max_lines(16'hFFFF);
    // Overlong lines past the buffer, then an unterminated final line.
    queue_line(260, 0, 0, 30, 0);
    queue_line(262, 0, 0, 2, 0);
    queue_item(OP_BYTE, CHAR_SPACE);
    queue_item(OP_BYTE, 8'h41);
    queue_item(OP_FINISH, 8'h00);
    wait_drained();

    // Random files; the limit changes between phases.
    n_items = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_max_lines(16'd3);
        1: write_max_lines(16'($urandom_range(1, 20)));
        2: write_max_lines(16'hFFFF);
        default: write_max_lines(MAX_LINES_RESET);
      endcase
      while (n_items < (phase + 1) * 200) begin
        int unsigned unit, n_lines;
        unit = $urandom_range(1, 8);
        n_lines = $urandom_range(1, 12);
        for (int l = 0; l < n_lines; l++) begin
          base = text_items.size();
          case ($urandom_range(0, 9))
            0: begin
              for (int k = 0; k < int'($urandom_range(1, 6)); k++)
                queue_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
            1: queue_line($urandom_range(0, 3), $urandom_range(0, 3),
                          1'($urandom_range(0, 1)), $urandom_range(0, 4),
                          1'($urandom_range(0, 1)));
            2: queue_line(0, $urandom_range(0, 4), 1, $urandom_range(0, 4), 0);
            default: queue_line(unit * $urandom_range(0, 4), 0, 0, $urandom_range(0, 5),
                                1'($urandom_range(0, 1)));
          endcase
          n_items += text_items.size() - base;
        end
        queue_item(OP_FINISH, 8'($urandom));
        n_items++;
        if (phase == 1 && !drained_once && n_items > 250) begin
          // Let the block drain completely before more text arrives.
          drained_once = 1'b1;
          wait_drained();
        end
      end
      wait_drained();
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
rtl/isd_pkg.sv
rtl/isd_divider.sv
rtl/isd_line_mem.sv
rtl/indent_style_detector_unit.sv
sim/indent_style_detector_unit_test.sv
